// File: rtl/core/bhcs_pkg.sv
// Package for the busy-line command sequencer: sizes, command and phase codes,
// and the structs passed between the control block and the top level.
// No dependencies.
package bhcs_pkg;

    // Frame buffer geometry
    localparam int FRAME_DEPTH = 512;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

    // Word field widths
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int RCV_W    = 9;
    localparam int TIMER_W  = 16;
    localparam int STATUS_W = 2;

    // Byte index must hold both the frame position and the read count
    localparam int IDX_W = (CNT_W > RCV_W + 1) ? CNT_W : RCV_W + 1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [BYTE_W-1:0]  FILL_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0]  ZERO_BYTE     = 8'h00;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [RCV_W-1:0]   rcv_t;
    typedef logic [TIMER_W-1:0] timer_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 2'd0,
        ST_OK      = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_WAIT_LOW1  = 3'd1,
        PH_WRITE      = 3'd2,
        PH_WAIT_HIGH1 = 3'd3,
        PH_WAIT_LOW2  = 3'd4,
        PH_READ       = 3'd5,
        PH_WAIT_HIGH2 = 3'd6,
        PH_WAIT_LOW3  = 3'd7
    } phase_t;

    // Result of one word; spi byte comes from the frame RAM when use_mem is set
    typedef struct packed {
        logic    select_level;
        logic    spi_out_valid;
        logic    use_mem;
        byte_t   spi_out_byte;
        logic    read_valid;
        byte_t   read_byte;
        logic    engine_busy;
        status_t finish_status;
    } res_t;

    // Frame RAM access plus result, from the control block
    typedef struct packed {
        logic  mem_we;
        addr_t mem_waddr;
        byte_t mem_wdata;
        logic  mem_re;
        addr_t mem_raddr;
        res_t  res;
    } step_t;

endpackage

// File: rtl/core/bhcs_ctrl.sv
// Handshake phase machine, counters and wait timer of the sequencer.
// Issues frame RAM writes for load words and reads for write-phase tick words.
// Depends on bhcs_pkg.
module bhcs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  bhcs_pkg::cmd_t       command,
    input  bhcs_pkg::byte_t      send_byte,
    input  bhcs_pkg::rcv_t       receive_count,
    input  logic                 busy_level,
    input  bhcs_pkg::byte_t      spi_in_byte,
    input  bhcs_pkg::timer_t     timeout_ticks,
    output bhcs_pkg::step_t      step
);

    bhcs_pkg::phase_t phase_reg, phase_next;
    bhcs_pkg::timer_t timer_reg, timer_next;
    bhcs_pkg::cnt_t   loaded_reg, loaded_next;
    bhcs_pkg::idx_t   idx_reg, idx_next;
    bhcs_pkg::rcv_t   read_total_reg, read_total_next;
    logic             select_reg, select_next;

    logic             want_high;
    logic             is_wait;
    bhcs_pkg::idx_t   idx_inc;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bhcs_pkg::PH_IDLE;
            timer_reg      <= '0;
            loaded_reg     <= '0;
            idx_reg        <= '0;
            read_total_reg <= '0;
            select_reg     <= 1'b1;
        end
        else
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            loaded_reg     <= loaded_next;
            idx_reg        <= idx_next;
            read_total_reg <= read_total_next;
            select_reg     <= select_next;
        end
    end

    // Next state and per-word result
    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        loaded_next     = loaded_reg;
        idx_next        = idx_reg;
        read_total_next = read_total_reg;
        select_next     = select_reg;
        step            = '0;
        want_high       = (phase_reg == bhcs_pkg::PH_WAIT_HIGH1) ||
                          (phase_reg == bhcs_pkg::PH_WAIT_HIGH2);
        is_wait         = (phase_reg != bhcs_pkg::PH_WRITE) &&
                          (phase_reg != bhcs_pkg::PH_READ);
        idx_inc         = idx_reg;

        if (fire)
        begin
            unique case (command)
                bhcs_pkg::CMD_LOAD:
                begin
                    if (phase_reg == bhcs_pkg::PH_IDLE &&
                        loaded_reg < bhcs_pkg::cnt_t'(bhcs_pkg::FRAME_DEPTH))
                    begin
                        step.mem_we    = 1'b1;
                        step.mem_waddr = loaded_reg[bhcs_pkg::ADDR_W-1:0];
                        step.mem_wdata = send_byte;
                        loaded_next    = loaded_reg + 1'b1;
                    end
                end
                bhcs_pkg::CMD_START:
                begin
                    if (phase_reg == bhcs_pkg::PH_IDLE)
                    begin
                        read_total_next = receive_count;
                        idx_next        = '0;
                        phase_next      = bhcs_pkg::PH_WAIT_LOW1;
                        timer_next      = '0;
                    end
                end
                bhcs_pkg::CMD_TICK:
                begin
                    if (phase_reg != bhcs_pkg::PH_IDLE)
                    begin
                        if (is_wait && (busy_level != want_high))
                        begin
                            // busy line not there yet: count or give up
                            if (timer_reg >= timeout_ticks)
                            begin
                                phase_next  = bhcs_pkg::PH_IDLE;
                                select_next = 1'b1;
                                loaded_next = '0;
                                idx_next    = '0;
                                timer_next  = '0;
                                step.res.finish_status = bhcs_pkg::ST_TIMEOUT;
                            end
                            else
                            begin
                                timer_next = timer_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            unique case (phase_reg)
                                bhcs_pkg::PH_WAIT_LOW1:
                                begin
                                    select_next = 1'b0;
                                    idx_next    = '0;
                                    phase_next  = bhcs_pkg::PH_WRITE;
                                    timer_next  = '0;
                                end
                                bhcs_pkg::PH_WRITE:
                                begin
                                    if (idx_reg < bhcs_pkg::idx_t'(loaded_reg))
                                    begin
                                        step.mem_re            = 1'b1;
                                        step.mem_raddr         =
                                            idx_reg[bhcs_pkg::ADDR_W-1:0];
                                        step.res.spi_out_valid = 1'b1;
                                        step.res.use_mem       = 1'b1;
                                        idx_inc                = idx_reg + 1'b1;
                                    end
                                    idx_next = idx_inc;
                                    if (idx_inc >= bhcs_pkg::idx_t'(loaded_reg))
                                    begin
                                        phase_next = bhcs_pkg::PH_WAIT_HIGH1;
                                        timer_next = '0;
                                    end
                                end
                                bhcs_pkg::PH_WAIT_HIGH1:
                                begin
                                    select_next = 1'b1;
                                    phase_next  = bhcs_pkg::PH_WAIT_LOW2;
                                    timer_next  = '0;
                                end
                                bhcs_pkg::PH_WAIT_LOW2:
                                begin
                                    if (read_total_reg == '0)
                                    begin
                                        phase_next  = bhcs_pkg::PH_IDLE;
                                        select_next = 1'b1;
                                        loaded_next = '0;
                                        idx_next    = '0;
                                        timer_next  = '0;
                                        step.res.finish_status = bhcs_pkg::ST_OK;
                                    end
                                    else
                                    begin
                                        select_next = 1'b0;
                                        idx_next    = '0;
                                        phase_next  = bhcs_pkg::PH_READ;
                                        timer_next  = '0;
                                    end
                                end
                                bhcs_pkg::PH_READ:
                                begin
                                    step.res.spi_out_valid = 1'b1;
                                    step.res.spi_out_byte  = bhcs_pkg::FILL_BYTE;
                                    step.res.read_valid    = 1'b1;
                                    step.res.read_byte     = spi_in_byte;
                                    idx_inc                = idx_reg + 1'b1;
                                    idx_next               = idx_inc;
                                    if (idx_inc >= bhcs_pkg::idx_t'(read_total_reg))
                                    begin
                                        phase_next = bhcs_pkg::PH_WAIT_HIGH2;
                                        timer_next = '0;
                                    end
                                end
                                bhcs_pkg::PH_WAIT_HIGH2:
                                begin
                                    select_next = 1'b1;
                                    phase_next  = bhcs_pkg::PH_WAIT_LOW3;
                                    timer_next  = '0;
                                end
                                default:
                                begin
                                    // final busy-low wait met: transaction done
                                    phase_next  = bhcs_pkg::PH_IDLE;
                                    select_next = 1'b1;
                                    loaded_next = '0;
                                    idx_next    = '0;
                                    timer_next  = '0;
                                    step.res.finish_status = bhcs_pkg::ST_OK;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        step.res.select_level = select_next;
        step.res.engine_busy  = (phase_next != bhcs_pkg::PH_IDLE);
    end

endmodule

// File: rtl/core/busy_handshake_command_sequencer.sv
// Busy-line command sequencer: frame RAM, result pipeline and stream ports.
// Depends on bhcs_pkg and bhcs_ctrl.
//
// Takes one word per clock while the output side is ready and returns exactly
// one result word for each, through a stage-one and an output register. Load
// words fill a 512-byte frame RAM; a start word opens a transaction and each
// tick word moves the busy-line handshake on by one step or one byte exchange.
// Frame bytes sent in the write phase come out of the single-port-read frame
// RAM, whose registered read lines up with the stage-one register; both stages
// hold results under output stalls, and the input is held off once both are full.
// timeout_ticks is written through cfg_wr_en/cfg_wr_data and resets to 500.
module busy_handshake_command_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: timeout_ticks
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // send_byte[7:0], receive_count[16:8],
                                  // busy_level[17], spi_in_byte[25:18], zero pad
    input  logic [1:0]  s_tuser,  // command[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // select_level[0], spi_out_valid[1],
                                  // spi_out_byte[9:2], read_valid[10],
                                  // read_byte[18:11], engine_busy[19],
                                  // finish_status[21:20], zero pad
);

    bhcs_pkg::timer_t timeout_reg;
    bhcs_pkg::step_t  step;
    logic             fire;

    bhcs_pkg::byte_t  frame_mem [bhcs_pkg::FRAME_DEPTH];
    bhcs_pkg::byte_t  rdata_reg;

    logic             s1_valid_reg;
    bhcs_pkg::res_t   s1_reg;
    logic             out_valid_reg;
    bhcs_pkg::res_t   out_reg;
    bhcs_pkg::res_t   s1_res;
    logic             out_free;
    logic             s1_move;

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= bhcs_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Handshake and pipeline flow
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign fire     = s_tvalid && s_tready;

    bhcs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .command       (bhcs_pkg::cmd_t'(s_tuser)),
        .send_byte     (s_tdata[7:0]),
        .receive_count (s_tdata[16:8]),
        .busy_level    (s_tdata[17]),
        .spi_in_byte   (s_tdata[25:18]),
        .timeout_ticks (timeout_reg),
        .step          (step)
    );

    // Frame RAM, registered read
    always_ff @(posedge clk)
    begin
        if (step.mem_we)
        begin
            frame_mem[step.mem_waddr] <= step.mem_wdata;
        end
        if (step.mem_re)
        begin
            rdata_reg <= frame_mem[step.mem_raddr];
        end
    end

    // Merge RAM data into the stage-one result
    always_comb
    begin
        s1_res = s1_reg;
        if (s1_reg.use_mem)
        begin
            s1_res.spi_out_byte = rdata_reg;
        end
        s1_res.use_mem = 1'b0;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg <= step.res;
        end
        if (s1_move)
        begin
            out_reg <= s1_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.finish_status,
                       out_reg.engine_busy,
                       out_reg.read_byte,
                       out_reg.read_valid,
                       out_reg.spi_out_byte,
                       out_reg.spi_out_valid,
                       out_reg.select_level};

endmodule
